/* rtl/mjt_pkg.sv */
// ----------------------------------------------------------------------------
// mjt_pkg
// Shared types, codes and saturating helpers for the minimum-jerk generator.
// ----------------------------------------------------------------------------
package mjt_pkg;

	// fraction bits of normalized time s (unsigned Q2.28)
	localparam int S_FRAC = 28;

	// configuration register indexes
	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_START_POS = 3'd0;
	localparam reg_idx_t REG_START_VEL = 3'd1;
	localparam reg_idx_t REG_START_ACC = 3'd2;
	localparam reg_idx_t REG_END_POS   = 3'd3;
	localparam reg_idx_t REG_END_VEL   = 3'd4;
	localparam reg_idx_t REG_END_ACC   = 3'd5;
	localparam reg_idx_t REG_PERIOD    = 3'd6;
	localparam reg_idx_t REG_DURATION  = 3'd7;

	// post-multiply scaling
	typedef logic [1:0] shift_t;
	localparam shift_t SH_NONE  = 2'd0;
	localparam shift_t SH_FRAC  = 2'd1;
	localparam shift_t SH_FRAC1 = 2'd2;
	localparam shift_t SH_S     = 2'd3;

	// arithmetic unit operation
	typedef logic op_t;
	localparam op_t OP_MUL = 1'b0;
	localparam op_t OP_DIV = 1'b1;

	typedef struct packed {
		logic   start;
		op_t    op;
		shift_t sh;
	} unit_ctl_t;

	localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? S64_MIN : S64_MAX;
		end
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? S64_MIN : S64_MAX;
		end
		return s[63:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
		if (a[63] && !(&a[62:31])) begin
			return {1'b1, {31{1'b0}}};
		end
		if (!a[63] && (|a[62:31])) begin
			return {1'b0, {31{1'b1}}};
		end
		return a[31:0];
	endfunction

endpackage

/* rtl/mjt_arith_unit.sv */
// ----------------------------------------------------------------------------
// mjt_arith_unit
// Shared shift-add multiplier with rounding/saturation and restoring divider.
// ----------------------------------------------------------------------------
module mjt_arith_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mjt_pkg::unit_ctl_t ctl,
	input  logic signed [63:0] opa,
	input  logic [63:0]        opb,
	input  logic [95:0]        dividend,
	input  logic [6:0]         div_steps,
	output logic               done,
	output logic signed [63:0] prod_sat,
	output logic [63:0]        prod_raw,
	output logic [95:0]        quotient,
	output logic [31:0]        remainder
);

	logic              busy_q, done_q, neg_q;
	mjt_pkg::op_t      op_q;
	mjt_pkg::shift_t   sh_q;
	logic [127:0]      acc_q, mcand_q;
	logic [63:0]       mplier_q;
	logic [95:0]       dvd_q, quo_q;
	logic [31:0]       dsr_q, rem_q;
	logic [6:0]        cnt_q;

	logic [63:0]  opa_u, mag;
	logic [127:0] rnd, shifted;
	logic [32:0]  rem_sh, rem_diff;
	logic         rem_ge, ovf, finish;

	always_comb begin
		opa_u = opa;
		mag = opa_u[63] ? (64'd0 - opa_u) : opa_u;
		case (ctl.sh)
			mjt_pkg::SH_FRAC:  rnd = 128'd1 << (FRAC_BITS - 1);
			mjt_pkg::SH_FRAC1: rnd = 128'd1 << FRAC_BITS;
			mjt_pkg::SH_S:     rnd = 128'd1 << (mjt_pkg::S_FRAC - 1);
			default:           rnd = '0;
		endcase
		rem_sh = {rem_q, dvd_q[95]};
		rem_ge = rem_sh >= {1'b0, dsr_q};
		rem_diff = rem_sh - {1'b0, dsr_q};
		finish = (op_q == mjt_pkg::OP_MUL) ? (mplier_q == '0) : (cnt_q == '0);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !ctl.start && busy_q && finish;
			if (ctl.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && finish) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath: load on start, one multiplier bit or one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			op_q     <= ctl.op;
			sh_q     <= ctl.sh;
			neg_q    <= opa_u[63];
			acc_q    <= rnd;
			mcand_q  <= {64'd0, mag};
			mplier_q <= opb;
			dvd_q    <= dividend;
			dsr_q    <= opb[31:0];
			rem_q    <= '0;
			quo_q    <= '0;
			cnt_q    <= div_steps;
		end else if (busy_q && !finish) begin
			if (op_q == mjt_pkg::OP_MUL) begin
				if (mplier_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
			end else begin
				rem_q <= rem_ge ? rem_diff[31:0] : rem_sh[31:0];
				quo_q <= {quo_q[94:0], rem_ge};
				dvd_q <= dvd_q << 1;
				cnt_q <= cnt_q - 7'd1;
			end
		end
	end

	always_comb begin
		case (sh_q)
			mjt_pkg::SH_FRAC:  shifted = acc_q >> FRAC_BITS;
			mjt_pkg::SH_FRAC1: shifted = acc_q >> (FRAC_BITS + 1);
			mjt_pkg::SH_S:     shifted = acc_q >> mjt_pkg::S_FRAC;
			default:           shifted = acc_q;
		endcase
		ovf = (|shifted[127:64]) || (shifted[63] && (!neg_q || (|shifted[62:0])));
		if (ovf) begin
			prod_sat = neg_q ? mjt_pkg::S64_MIN : mjt_pkg::S64_MAX;
		end else begin
			prod_sat = neg_q ? (64'd0 - shifted[63:0]) : shifted[63:0];
		end
	end

	assign done      = done_q;
	assign prod_raw  = acc_q[63:0];
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* rtl/min_jerk_trajectory_gen_top.sv */
// ----------------------------------------------------------------------------
// min_jerk_trajectory_gen_top
// Quintic minimum-jerk position profile generator, one sample per tick.
// ----------------------------------------------------------------------------
// A tick beat with restart set latches a new profile from the configuration
// registers (end-point deltas folded into three coefficients) and returns
// sample 0; each later tick returns the next sample until the one flagged
// last, after which ticks return nothing until the next restart. Every
// product goes through one shared shift-add multiplier that retires one
// multiplier bit per cycle, and divisions through the same unit at one
// quotient bit per cycle. The time a sample takes grows with the bit
// lengths of the multiplier operands (period, three times the sample time,
// four times normalized time and three times its powers), and a restart
// adds the coefficient products before sample 0. The tick side stalls while
// a beat is being worked on. Configuration is taken at any time on its own
// channel and must only change while the block is idle.
module min_jerk_trajectory_gen_top #(
	parameter int FRAC_BITS = 16,
	parameter int STEP_BITS = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	// tick channel
	input  logic               tick_valid,
	output logic               tick_stall,
	input  logic               restart,
	// sample channel
	output logic               sample_valid,
	input  logic               sample_stall,
	output logic signed [31:0] position,
	output logic [19:0]        sample_index,
	output logic               last,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	// sequencer states, in issue order; each unit state advances by one
	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_NDIV = 5'd1;
	localparam logic [4:0] ST_AST  = 5'd2;
	localparam logic [4:0] ST_VT   = 5'd3;
	localparam logic [4:0] ST_H    = 5'd4;
	localparam logic [4:0] ST_E1   = 5'd5;
	localparam logic [4:0] ST_X    = 5'd6;
	localparam logic [4:0] ST_H2   = 5'd7;
	localparam logic [4:0] ST_M10  = 5'd8;
	localparam logic [4:0] ST_M4   = 5'd9;
	localparam logic [4:0] ST_M7   = 5'd10;
	localparam logic [4:0] ST_M15  = 5'd11;
	localparam logic [4:0] ST_M6   = 5'd12;
	localparam logic [4:0] ST_M3   = 5'd13;
	localparam logic [4:0] ST_CFIN = 5'd14;
	localparam logic [4:0] ST_TMUL = 5'd15;
	localparam logic [4:0] ST_SDIV = 5'd16;
	localparam logic [4:0] ST_VT2  = 5'd17;
	localparam logic [4:0] ST_AT   = 5'd18;
	localparam logic [4:0] ST_AT2  = 5'd19;
	localparam logic [4:0] ST_S2   = 5'd20;
	localparam logic [4:0] ST_S3   = 5'd21;
	localparam logic [4:0] ST_C3   = 5'd22;
	localparam logic [4:0] ST_S4   = 5'd23;
	localparam logic [4:0] ST_C4   = 5'd24;
	localparam logic [4:0] ST_S5   = 5'd25;
	localparam logic [4:0] ST_C5   = 5'd26;
	localparam logic [4:0] ST_OUT  = 5'd27;

	localparam logic [32:0] STEP_CAP = 33'((64'd1 << STEP_BITS) - 64'd2);
	localparam logic [29:0] S_TWO    = 30'd1 << (mjt_pkg::S_FRAC + 1);
	// dividend bits for t * 2^(S_FRAC+1) / T
	localparam logic [6:0]  SDIV_STEPS = 7'(64 + mjt_pkg::S_FRAC + 1);

	// configuration registers
	logic [31:0] ps_q, vs_q, as_q, pe_q, ve_q, ae_q, per_q, dur_q;

	// sequencer and profile state
	logic [4:0]           state_q;
	logic                 issued_q, running_q;
	logic [STEP_BITS-1:0] step_q, total_q;
	logic signed [63:0]   c3_q, c4_q, c5_q;
	logic signed [63:0]   ast_q, d0_q, d1_q, e1_q, tmp_q, h2_q, e2_q, acc_q;
	logic [63:0]          t_q;
	logic [29:0]          s_q;
	logic [33:0]          pw_q;

	// output register
	logic               out_valid_q, out_last_q;
	logic signed [31:0] out_pos_q;
	logic [19:0]        out_idx_q;

	// unit interface
	mjt_pkg::unit_ctl_t u_ctl;
	logic signed [63:0] u_a, u_sat;
	logic [63:0]        u_b, u_raw;
	logic [95:0]        u_dvd, u_quo;
	logic [6:0]         u_steps;
	logic [31:0]        u_rem;
	logic               u_done, unit_state;

	// derived operands
	logic signed [63:0] ps64, vs64, as64, pe_m_ps, ve_m_vs, d2;
	logic [31:0]        per_eff, dur_eff;
	logic [32:0]        n_rnd, n_cap;
	logic [31:0]        s_half;
	logic [29:0]        s_next;
	logic [63:0]        step_ext;
	logic               out_fire, is_last;
	logic [STEP_BITS:0] step_inc;

	assign cfg_ready = 1'b1;

	// drop configuration beats into their registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q  <= '0;
			vs_q  <= '0;
			as_q  <= '0;
			pe_q  <= '0;
			ve_q  <= '0;
			ae_q  <= '0;
			per_q <= 32'd524;
			dur_q <= 32'd65536;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mjt_pkg::REG_START_POS: ps_q  <= cfg_data;
				mjt_pkg::REG_START_VEL: vs_q  <= cfg_data;
				mjt_pkg::REG_START_ACC: as_q  <= cfg_data;
				mjt_pkg::REG_END_POS:   pe_q  <= cfg_data;
				mjt_pkg::REG_END_VEL:   ve_q  <= cfg_data;
				mjt_pkg::REG_END_ACC:   ae_q  <= cfg_data;
				mjt_pkg::REG_PERIOD:    per_q <= cfg_data;
				mjt_pkg::REG_DURATION:  dur_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		ps64    = {{32{ps_q[31]}}, ps_q};
		vs64    = {{32{vs_q[31]}}, vs_q};
		as64    = {{32{as_q[31]}}, as_q};
		pe_m_ps = {{32{pe_q[31]}}, pe_q} - ps64;
		ve_m_vs = {{32{ve_q[31]}}, ve_q} - vs64;
		d2      = {{32{ae_q[31]}}, ae_q} - as64;
		// a zero period or duration counts as one LSB
		per_eff = (per_q == '0) ? 32'd1 : per_q;
		dur_eff = (dur_q == '0) ? 32'd1 : dur_q;
		step_ext = {{(64 - STEP_BITS){1'b0}}, step_q};

		// sample count: round T/period, capped
		n_rnd = {1'b0, u_quo[31:0]} + 33'({u_rem, 1'b0} >= {1'b0, per_eff});
		n_cap = (n_rnd > STEP_CAP) ? STEP_CAP : n_rnd;

		// s = round(t/T) in Q2.28, clamped to two
		s_half = ({1'b0, u_quo[30:0]} + 32'd1) >> 1;
		if ((|u_quo[95:31]) || (s_half > {2'b00, S_TWO})) begin
			s_next = S_TWO;
		end else begin
			s_next = s_half[29:0];
		end

		step_inc = {1'b0, step_q} + 1'b1;
		is_last  = step_inc >= {1'b0, total_q};
		out_fire = (state_q == ST_OUT) && (!out_valid_q || !sample_stall);
		unit_state = (state_q != ST_IDLE) && (state_q != ST_CFIN) && (state_q != ST_OUT);
	end

	// operand select for the shared unit
	always_comb begin
		u_ctl.start = unit_state && !issued_q;
		u_ctl.op    = mjt_pkg::OP_MUL;
		u_ctl.sh    = mjt_pkg::SH_NONE;
		u_a         = '0;
		u_b         = '0;
		u_dvd       = '0;
		u_steps     = '0;
		case (state_q)
			ST_NDIV: begin
				u_ctl.op = mjt_pkg::OP_DIV;
				u_dvd    = {dur_eff, 64'd0};
				u_b      = {32'd0, per_eff};
				u_steps  = 7'd32;
			end
			ST_AST: begin
				u_a = as64; u_b = {32'd0, dur_eff}; u_ctl.sh = mjt_pkg::SH_FRAC;
			end
			ST_VT: begin
				u_a = vs64; u_b = {32'd0, dur_eff}; u_ctl.sh = mjt_pkg::SH_FRAC;
			end
			ST_H: begin
				u_a = ast_q; u_b = {32'd0, dur_eff}; u_ctl.sh = mjt_pkg::SH_FRAC1;
			end
			ST_E1: begin
				u_a = d1_q; u_b = {32'd0, dur_eff}; u_ctl.sh = mjt_pkg::SH_FRAC;
			end
			ST_X: begin
				u_a = d2; u_b = {32'd0, dur_eff}; u_ctl.sh = mjt_pkg::SH_FRAC;
			end
			ST_H2: begin
				u_a = tmp_q; u_b = {32'd0, dur_eff}; u_ctl.sh = mjt_pkg::SH_FRAC1;
			end
			ST_M10: begin u_a = d0_q; u_b = 64'd10; end
			ST_M4:  begin u_a = e1_q; u_b = 64'd4;  end
			ST_M7:  begin u_a = e1_q; u_b = 64'd7;  end
			ST_M15: begin u_a = d0_q; u_b = 64'd15; end
			ST_M6:  begin u_a = d0_q; u_b = 64'd6;  end
			ST_M3:  begin u_a = e1_q; u_b = 64'd3;  end
			ST_TMUL: begin
				u_a = step_ext; u_b = {32'd0, per_eff};
			end
			ST_SDIV: begin
				u_ctl.op = mjt_pkg::OP_DIV;
				u_dvd    = {t_q, 32'd0};
				u_b      = {32'd0, dur_eff};
				u_steps  = SDIV_STEPS;
			end
			ST_VT2: begin u_a = vs64;  u_b = t_q; u_ctl.sh = mjt_pkg::SH_FRAC;  end
			ST_AT:  begin u_a = as64;  u_b = t_q; u_ctl.sh = mjt_pkg::SH_FRAC;  end
			ST_AT2: begin u_a = tmp_q; u_b = t_q; u_ctl.sh = mjt_pkg::SH_FRAC1; end
			ST_S2: begin
				u_a = {34'd0, s_q}; u_b = {34'd0, s_q}; u_ctl.sh = mjt_pkg::SH_S;
			end
			ST_S3, ST_S4, ST_S5: begin
				u_a = {30'd0, pw_q}; u_b = {34'd0, s_q}; u_ctl.sh = mjt_pkg::SH_S;
			end
			ST_C3: begin u_a = c3_q; u_b = {30'd0, pw_q}; u_ctl.sh = mjt_pkg::SH_S; end
			ST_C4: begin u_a = c4_q; u_b = {30'd0, pw_q}; u_ctl.sh = mjt_pkg::SH_S; end
			ST_C5: begin u_a = c5_q; u_b = {30'd0, pw_q}; u_ctl.sh = mjt_pkg::SH_S; end
			default: ;
		endcase
	end

	mjt_arith_unit #(
		.FRAC_BITS(FRAC_BITS)
	) u_arith (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (u_ctl),
		.opa       (u_a),
		.opb       (u_b),
		.dividend  (u_dvd),
		.div_steps (u_steps),
		.done      (u_done),
		.prod_sat  (u_sat),
		.prod_raw  (u_raw),
		.quotient  (u_quo),
		.remainder (u_rem)
	);

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			running_q   <= 1'b0;
			step_q      <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new sample, or drop the old one once it is taken
			out_valid_q <= out_fire || (out_valid_q && sample_stall);
			if (state_q == ST_IDLE) begin
				if (tick_valid) begin
					if (restart) begin
						state_q <= ST_NDIV;
					end else if (running_q) begin
						state_q <= ST_TMUL;
					end
				end
			end else if (state_q == ST_CFIN) begin
				step_q    <= '0;
				running_q <= 1'b1;
				state_q   <= ST_TMUL;
			end else if (state_q == ST_OUT) begin
				// hold until the output register is free
				if (out_fire) begin
					step_q      <= step_inc[STEP_BITS-1:0];
					if (is_last) begin
						running_q <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
			end else if (u_ctl.start) begin
				issued_q <= 1'b1;
			end else if (u_done) begin
				issued_q <= 1'b0;
				state_q  <= state_q + 5'd1;
				if (state_q == ST_NDIV) begin
					total_q <= STEP_BITS'(n_cap + 33'd1);
				end
			end
		end
	end

	// capture unit results into the working registers
	always_ff @(posedge clk) begin
		if (state_q == ST_CFIN) begin
			c5_q <= mjt_pkg::sadd(c5_q, h2_q);
		end
		if (out_fire) begin
			out_pos_q  <= mjt_pkg::sat32(acc_q);
			out_idx_q  <= step_ext[19:0];
			out_last_q <= is_last;
		end
		if (unit_state && issued_q && u_done) begin
			case (state_q)
				ST_AST: ast_q <= u_sat;
				ST_VT:  d0_q  <= mjt_pkg::ssub(pe_m_ps, u_sat);
				ST_H: begin
					d0_q <= mjt_pkg::ssub(d0_q, u_sat);
					d1_q <= mjt_pkg::ssub(ve_m_vs, ast_q);
				end
				ST_E1:  e1_q <= u_sat;
				ST_X:   tmp_q <= u_sat;
				ST_H2: begin
					h2_q <= u_sat;
					e2_q <= mjt_pkg::sadd(u_sat, u_sat);
				end
				ST_M10: c3_q <= u_sat;
				ST_M4:  c3_q <= mjt_pkg::ssub(c3_q, u_sat);
				ST_M7: begin
					c4_q <= u_sat;
					c3_q <= mjt_pkg::sadd(c3_q, h2_q);
				end
				ST_M15: c4_q <= mjt_pkg::ssub(c4_q, u_sat);
				ST_M6: begin
					c5_q <= u_sat;
					c4_q <= mjt_pkg::ssub(c4_q, e2_q);
				end
				ST_M3:   c5_q <= mjt_pkg::ssub(c5_q, u_sat);
				ST_TMUL: t_q <= u_raw;
				ST_SDIV: s_q <= s_next;
				ST_VT2:  acc_q <= mjt_pkg::sadd(ps64, u_sat);
				ST_AT:   tmp_q <= u_sat;
				ST_AT2, ST_C3, ST_C4, ST_C5: acc_q <= mjt_pkg::sadd(acc_q, u_sat);
				ST_S2, ST_S3, ST_S4, ST_S5: pw_q <= u_sat[33:0];
				default: ;
			endcase
		end
	end

	assign tick_stall   = (state_q != ST_IDLE);
	assign sample_valid = out_valid_q;
	assign position     = out_pos_q;
	assign sample_index = out_idx_q;
	assign last         = out_last_q;

endmodule

/* rtl/mjt_checker.sv */
// ----------------------------------------------------------------------------
// mjt_checker
// Port-level checks on the sample stream of the minimum-jerk generator.
// ----------------------------------------------------------------------------
module mjt_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               sample_valid,
	input logic               sample_stall,
	input logic signed [31:0] position,
	input logic [19:0]        sample_index,
	input logic               last
);

	logic        have_q, prev_last_q;
	logic [19:0] prev_idx_q;
	logic        beat;

	assign beat = sample_valid && !sample_stall;

	// track the previous sample beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q      <= 1'b0;
			prev_last_q <= 1'b0;
			prev_idx_q  <= '0;
		end else if (beat) begin
			have_q      <= 1'b1;
			prev_last_q <= last;
			prev_idx_q  <= sample_index;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_stall |=> sample_valid && $stable(position)
			&& $stable(sample_index) && $stable(last))
		else $error("stalled sample beat changed");

	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		beat && have_q && !prev_last_q |->
			(sample_index == prev_idx_q + 20'd1) || (sample_index == 20'd0))
		else $error("sample index skipped");

	a_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		beat && have_q && prev_last_q |-> sample_index == 20'd0)
		else $error("sample after last did not start a new profile");

endmodule

bind min_jerk_trajectory_gen_top mjt_checker u_mjt_checker (.*);
